// File: sv/itc_pkg.sv
// ----------------------------------------------------------------------------
// itc_pkg
// Shared types, codes and widths for the interval timer counter unit.
// ----------------------------------------------------------------------------
package itc_pkg;

	// width of the down counter and reload registers (8 to 32)
	localparam int COUNT_BITS = 16;
	// width used when slicing count bytes, at least two bytes wide
	localparam int EXT_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	typedef logic [COUNT_BITS-1:0] count_t;

	// item kinds
	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_TICK  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	// register selects
	localparam logic [1:0] PORT_DATA0 = 2'd0;
	localparam logic [1:0] PORT_CTRL  = 2'd3;

	// control word fields
	localparam logic [1:0] SEL_CNT0   = 2'd0;
	localparam logic [1:0] ACC_LATCH  = 2'd0;
	localparam logic [1:0] ACC_LOHI   = 2'd3;
	localparam logic [2:0] MODE_ONESHOT = 3'b000;

	// one input beat as seen by the counter core
	typedef struct packed {
		logic [1:0] func;
		logic [1:0] port;
		logic [7:0] wdata;
	} itc_item_t;

	// result of one beat
	typedef struct packed {
		logic [7:0] rdata;
		logic       out_level;
	} itc_result_t;

endpackage

// File: sv/interval_timer_counter_unit.sv
// ----------------------------------------------------------------------------
// interval_timer_counter_unit
// Counter zero of an interval timer driven by write, read and tick beats.
// ----------------------------------------------------------------------------
// path: an input beat passes the input register, then the counter update
//   feeding the result register
// throughput: one beat per cycle while out_stall does not hold the result register
// reset: asynchronous, clears all control state; the core's output pin state resets high
// ----------------------------------------------------------------------------
module interval_timer_counter_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [1:0] port,
	input  logic [7:0] wdata,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] rdata,
	output logic       out_level
);

	logic                  valid_s1;
	itc_pkg::itc_item_t    item_s1;
	logic                  advance;
	itc_pkg::itc_result_t  result;
	logic                  out_valid_q;
	logic [7:0]            rdata_q;
	logic                  out_level_q;

	// stage one moves on when the result register is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.func  <= func;
			item_s1.port  <= port;
			item_s1.wdata <= wdata;
		end
	end

	// counter state and update
	itc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rdata_q     <= result.rdata;
			out_level_q <= result.out_level;
		end
	end

	assign out_valid = out_valid_q;
	assign rdata     = rdata_q;
	assign out_level = out_level_q;

endmodule

// File: sv/itc_core.sv
// ----------------------------------------------------------------------------
// itc_core
// Counter zero state and its single-pass update for one write, read or tick.
// ----------------------------------------------------------------------------
module itc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  itc_pkg::itc_item_t  item,
	output itc_pkg::itc_result_t result
);

	logic              mode_periodic_q, mode_periodic_d;
	itc_pkg::count_t   reload_q, reload_d;
	itc_pkg::count_t   count_q, count_d;
	itc_pkg::count_t   latch_q, latch_d;
	logic              latch_held_q, latch_held_d;
	logic              wr_msb_q, wr_msb_d;
	logic              rd_msb_q, rd_msb_d;
	logic              running_q, running_d;
	logic              out_pin_q, out_pin_d;
	logic [7:0]        rdata_d;

	logic [1:0]        ctl_sel;
	logic [1:0]        ctl_acc;
	logic [2:0]        ctl_mode;
	logic              ctl_bcd;
	logic              mode_ok;
	logic              mode_new;
	itc_pkg::count_t   count_dec;
	itc_pkg::count_t   read_src;
	logic [itc_pkg::EXT_BITS-1:0] read_ext;
	logic [15:0]       reload_hi16;

	assign ctl_sel  = item.wdata[7:6];
	assign ctl_acc  = item.wdata[5:4];
	assign ctl_mode = item.wdata[3:1];
	assign ctl_bcd  = item.wdata[0];
	assign count_dec = count_q - itc_pkg::COUNT_BITS'(1);
	assign read_src  = latch_held_q ? latch_q : count_q;
	assign read_ext  = itc_pkg::EXT_BITS'(read_src);
	// high byte write: new byte over the held low byte, fit to the count width
	assign reload_hi16 = {item.wdata, reload_q[7:0]};

	// decode of the programmable modes
	always_comb begin
		mode_ok  = 1'b0;
		mode_new = 1'b0;
		case (ctl_mode) inside
			itc_pkg::MODE_ONESHOT: begin
				mode_ok  = 1'b1;
				mode_new = 1'b0;
			end
			3'b010, 3'b110: begin
				mode_ok  = 1'b1;
				mode_new = 1'b1;
			end
			default: begin
				mode_ok  = 1'b0;
				mode_new = 1'b0;
			end
		endcase
	end

	// next state and read byte for the current beat
	always_comb begin
		mode_periodic_d = mode_periodic_q;
		reload_d        = reload_q;
		count_d         = count_q;
		latch_d         = latch_q;
		latch_held_d    = latch_held_q;
		wr_msb_d        = wr_msb_q;
		rd_msb_d        = rd_msb_q;
		running_d       = running_q;
		out_pin_d       = out_pin_q;
		rdata_d         = 8'd0;
		case (itc_pkg::func_t'(item.func))
			itc_pkg::FUNC_WRITE: begin
				if (item.port == itc_pkg::PORT_CTRL) begin
					if (ctl_sel == itc_pkg::SEL_CNT0) begin
						if (ctl_acc == itc_pkg::ACC_LATCH) begin
							if (!latch_held_q) begin
								latch_d      = count_q;
								latch_held_d = 1'b1;
							end
						end else if (ctl_acc == itc_pkg::ACC_LOHI && !ctl_bcd && mode_ok) begin
							mode_periodic_d = mode_new;
							running_d       = 1'b0;
							wr_msb_d        = 1'b0;
							rd_msb_d        = 1'b0;
							latch_held_d    = 1'b0;
							out_pin_d       = mode_new;
						end
					end
				end else if (item.port == itc_pkg::PORT_DATA0) begin
					if (!wr_msb_q) begin
						reload_d[7:0] = item.wdata;
						wr_msb_d      = 1'b1;
						if (!mode_periodic_q) begin
							running_d = 1'b0;
							out_pin_d = 1'b0;
						end
					end else begin
						reload_d  = itc_pkg::COUNT_BITS'(reload_hi16);
						wr_msb_d  = 1'b0;
						count_d   = itc_pkg::COUNT_BITS'(reload_hi16);
						running_d = 1'b1;
						out_pin_d = mode_periodic_q;
					end
				end
			end
			itc_pkg::FUNC_READ: begin
				if (item.port == itc_pkg::PORT_DATA0) begin
					if (!rd_msb_q) begin
						rdata_d  = read_ext[7:0];
						rd_msb_d = 1'b1;
					end else begin
						rdata_d      = read_ext[15:8];
						rd_msb_d     = 1'b0;
						latch_held_d = 1'b0;
					end
				end
			end
			itc_pkg::FUNC_TICK: begin
				if (running_q) begin
					if (!mode_periodic_q) begin
						count_d = count_dec;
						if (count_dec == '0) begin
							out_pin_d = 1'b1;
						end
					end else if (count_q == itc_pkg::COUNT_BITS'(1)) begin
						count_d   = reload_q;
						out_pin_d = 1'b1;
					end else begin
						count_d   = count_dec;
						out_pin_d = (count_dec != itc_pkg::COUNT_BITS'(1));
					end
				end
			end
			default: begin
				rdata_d = 8'd0;
			end
		endcase
	end

	// counter state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_periodic_q <= 1'b0;
			reload_q        <= '0;
			count_q         <= '0;
			latch_q         <= '0;
			latch_held_q    <= 1'b0;
			wr_msb_q        <= 1'b0;
			rd_msb_q        <= 1'b0;
			running_q       <= 1'b0;
			out_pin_q       <= 1'b1;
		end else if (step) begin
			mode_periodic_q <= mode_periodic_d;
			reload_q        <= reload_d;
			count_q         <= count_d;
			latch_q         <= latch_d;
			latch_held_q    <= latch_held_d;
			wr_msb_q        <= wr_msb_d;
			rd_msb_q        <= rd_msb_d;
			running_q       <= running_d;
			out_pin_q       <= out_pin_d;
		end
	end

	assign result.rdata     = rdata_d;
	assign result.out_level = out_pin_d;

endmodule
